>>> design/sbrm_pkg.sv
// shared types, widths and codes of the stereo block rms meter
package sbrm_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int MAX_FRAMES  = 4096;

  // frame count must hold MAX_FRAMES itself
  localparam int CNT_W  = $clog2(MAX_FRAMES + 1);
  // largest square is 2^(2*SAMPLE_BITS-2), summed over MAX_FRAMES frames
  localparam int SUM_W  = 2 * SAMPLE_BITS - 1 + $clog2(MAX_FRAMES);
  localparam int ROOT_W = SAMPLE_BITS;
  localparam int RAD_W  = 2 * ROOT_W;
  localparam int STEP_W = $clog2(SUM_W);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  // register indexes
  localparam logic [ADDR_W-3:0] REG_STEREO_MODE = '0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_SQRT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_left;
    logic signed [SAMPLE_BITS-1:0] sample_right;
    logic                          last_in_block;
  } frame_t;

  typedef struct packed {
    logic [ROOT_W-1:0] rms_left;
    logic [ROOT_W-1:0] rms_right;
    logic [CNT_W-1:0]  frames_in_block;
  } result_t;

endpackage

>>> design/stereo_block_rms_meter.sv
// top level of the stereo block rms meter: accumulate, divide and root
//
// usage
//   frame channel: frame_valid / frame_stall carry one stereo frame per transfer.
//   result channel: result_valid / result_stall carry one result per marked frame.
//   config port: APB-style, register 0 is stereo_mode (reset 1); the user writes it only while idle, not enforced.
// sequence
//   a frame is taken only in the idle state; each channel is squared by a
//   bit-serial shift-and-add over the SAMPLE_BITS multiplier bits; once the
//   block holds MAX_FRAMES frames, further frames are taken but not summed.
//   on the marked frame a restoring divider runs, then a two-bits-per-step
//   root, then the output state loads the result register.
// reset
//   synchronous, active high: sums and count cleared, stereo mode on, no result.
// stall
//   a finished result waits in its register while new frames are taken; a
//   second result waits in the output state until the first has gone.
module stereo_block_rms_meter (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             frame_valid,
  output logic                             frame_stall,
  input  sbrm_pkg::frame_t                 frame,
  output logic                             result_valid,
  input  logic                             result_stall,
  output sbrm_pkg::result_t                result,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sbrm_pkg::ADDR_W-1:0]      paddr,
  input  logic [sbrm_pkg::DATA_W-1:0]      pwdata,
  output logic [sbrm_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  localparam int SB     = sbrm_pkg::SAMPLE_BITS;
  localparam int CNT_W  = sbrm_pkg::CNT_W;
  localparam int SUM_W  = sbrm_pkg::SUM_W;
  localparam int ROOT_W = sbrm_pkg::ROOT_W;
  localparam int RAD_W  = sbrm_pkg::RAD_W;
  localparam int STEP_W = sbrm_pkg::STEP_W;
  localparam int ADDR_W = sbrm_pkg::ADDR_W;
  localparam int DATA_W = sbrm_pkg::DATA_W;

  // magnitude of a two's complement sample, the most negative code included
  function automatic logic [SB-1:0] magnitude(input logic [SB-1:0] s);
    logic [SB-1:0] m;
    m = s[SB-1] ? (~s + SB'(1)) : s;
    return m;
  endfunction

  sbrm_pkg::state_t state, state_next;
  logic [STEP_W-1:0] step;

  logic             stereo_mode;
  logic [CNT_W-1:0] frame_count;
  logic             last_q;

  // per channel: 0 left, 1 right
  logic [SUM_W-1:0]  sum    [2];   // accumulator, then dividend/quotient, then radicand
  logic [SUM_W-1:0]  mcand  [2];   // shifted square multiplicand
  logic [SB-1:0]     mplier [2];   // multiplier bits, lsb first
  logic [CNT_W-1:0]  rem    [2];   // divider remainder
  logic [ROOT_W+1:0] srem   [2];   // root remainder
  logic [ROOT_W-1:0] root   [2];

  logic [SB-1:0]     mag      [2];
  logic [CNT_W:0]    div_shift[2];
  logic [CNT_W:0]    div_diff [2];
  logic              div_ge   [2];
  logic [ROOT_W+3:0] sq_shift [2];
  logic [ROOT_W+3:0] sq_trial [2];
  logic [ROOT_W+3:0] sq_diff  [2];
  logic              sq_ge    [2];

  logic full;
  logic frame_take;
  logic result_free;
  logic cfg_write;

  assign full        = (frame_count == CNT_W'(sbrm_pkg::MAX_FRAMES));
  assign frame_take  = frame_valid && !frame_stall;
  assign result_free = !result_valid || !result_stall;

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[ADDR_W-1:2] == sbrm_pkg::REG_STEREO_MODE) ?
                     {{(DATA_W-1){1'b0}}, stereo_mode} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stereo_mode <= 1'b1;
    end else if (cfg_write && paddr[ADDR_W-1:2] == sbrm_pkg::REG_STEREO_MODE) begin
      stereo_mode <= pwdata[0];
    end
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbrm_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= (state_next != state) ? '0 : step + STEP_W'(1);
    end
  end

  // next state and frame stall
  always_comb begin
    state_next  = state;
    frame_stall = (state != sbrm_pkg::ST_IDLE);
    case (state)
      sbrm_pkg::ST_IDLE: begin
        if (frame_valid) begin
          if (!full) begin
            state_next = sbrm_pkg::ST_MUL;
          end else if (frame.last_in_block) begin
            state_next = sbrm_pkg::ST_DIV;
          end
        end
      end
      sbrm_pkg::ST_MUL: begin
        if (step == STEP_W'(SB - 1)) begin
          state_next = last_q ? sbrm_pkg::ST_DIV : sbrm_pkg::ST_IDLE;
        end
      end
      sbrm_pkg::ST_DIV: begin
        if (step == STEP_W'(SUM_W - 1)) begin
          state_next = sbrm_pkg::ST_SQRT;
        end
      end
      sbrm_pkg::ST_SQRT: begin
        if (step == STEP_W'(ROOT_W - 1)) begin
          state_next = sbrm_pkg::ST_OUT;
        end
      end
      sbrm_pkg::ST_OUT: begin
        if (result_free) begin
          state_next = sbrm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = sbrm_pkg::ST_IDLE;
      end
    endcase
  end

  // per-channel step logic, one quotient bit or one root bit a cycle
  always_comb begin
    mag[0] = magnitude(frame.sample_left);
    mag[1] = stereo_mode ? magnitude(frame.sample_right) : magnitude(frame.sample_left);
    for (int c = 0; c < 2; c++) begin
      div_shift[c] = {rem[c], sum[c][SUM_W-1]};
      div_ge[c]    = (div_shift[c] >= {1'b0, frame_count});
      div_diff[c]  = div_shift[c] - {1'b0, frame_count};
      sq_shift[c]  = {srem[c], sum[c][RAD_W-1 -: 2]};
      sq_trial[c]  = {2'b00, root[c], 2'b01};
      sq_ge[c]     = (sq_shift[c] >= sq_trial[c]);
      sq_diff[c]   = sq_shift[c] - sq_trial[c];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= '0;
      result_valid <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        sum[c] <= '0;
      end
    end else begin
      // the output state reloads the register itself when it frees up
      if (result_valid && !result_stall && state != sbrm_pkg::ST_OUT) begin
        result_valid <= 1'b0;
      end
      case (state)
        sbrm_pkg::ST_IDLE: begin
          if (frame_take) begin
            last_q <= frame.last_in_block;
            if (!full) begin
              frame_count <= frame_count + CNT_W'(1);
            end
            for (int c = 0; c < 2; c++) begin
              mcand[c]  <= SUM_W'(mag[c]);
              mplier[c] <= mag[c];
              rem[c]    <= '0;
              srem[c]   <= '0;
              root[c]   <= '0;
            end
          end
        end
        sbrm_pkg::ST_MUL: begin
          for (int c = 0; c < 2; c++) begin
            if (mplier[c][0]) begin
              sum[c] <= sum[c] + mcand[c];
            end
            mcand[c]  <= {mcand[c][SUM_W-2:0], 1'b0};
            mplier[c] <= {1'b0, mplier[c][SB-1:1]};
          end
        end
        sbrm_pkg::ST_DIV: begin
          // quotient bits shift in behind the dividend
          for (int c = 0; c < 2; c++) begin
            rem[c] <= div_ge[c] ? div_diff[c][CNT_W-1:0] : div_shift[c][CNT_W-1:0];
            sum[c] <= {sum[c][SUM_W-2:0], div_ge[c]};
          end
        end
        sbrm_pkg::ST_SQRT: begin
          for (int c = 0; c < 2; c++) begin
            srem[c] <= sq_ge[c] ? sq_diff[c][ROOT_W+1:0] : sq_shift[c][ROOT_W+1:0];
            root[c] <= {root[c][ROOT_W-2:0], sq_ge[c]};
            sum[c]  <= {sum[c][SUM_W-3:0], 2'b00};
          end
        end
        sbrm_pkg::ST_OUT: begin
          if (result_free) begin
            // an empty block reads as silence
            result.rms_left        <= (frame_count == '0) ? '0 : root[0];
            result.rms_right       <= (frame_count == '0) ? '0 : root[1];
            result.frames_in_block <= frame_count;
            result_valid           <= 1'b1;
            frame_count            <= '0;
            for (int c = 0; c < 2; c++) begin
              sum[c] <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// testbench of the stereo block rms meter: random and directed blocks against a level predictor
module tb_top;

  localparam int SAMPLE_BITS = sbrm_pkg::SAMPLE_BITS;
  localparam int MAX_FRAMES  = sbrm_pkg::MAX_FRAMES;
  localparam int CNT_W       = sbrm_pkg::CNT_W;
  localparam int SUM_W       = sbrm_pkg::SUM_W;
  localparam int ROOT_W      = sbrm_pkg::ROOT_W;
  localparam int ADDR_W      = sbrm_pkg::ADDR_W;
  localparam int DATA_W      = sbrm_pkg::DATA_W;

  localparam int WATCHDOG_LIMIT = 20000;
  // longer than one frame plus the divide and root at block end
  localparam int SETTLE_CYCLES  = 150;
  localparam int RANDOM_FRAMES  = 1250;
  localparam int MISMATCH_SHOWN = 10;
  // register index with nothing behind it, writes there must be dropped
  localparam logic [ADDR_W-3:0] REG_PAST_END = 1'b1;

  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] ONE_LSB  = 1;
  localparam logic signed [SAMPLE_BITS-1:0] MINUS_ONE = -1;
  localparam logic signed [SAMPLE_BITS-1:0] SILENCE  = 0;

  logic                clk          = 1'b0;
  logic                rst          = 1'b1;
  logic                frame_valid  = 1'b0;
  logic                frame_stall;
  sbrm_pkg::frame_t    frame        = '0;
  logic                result_valid;
  logic                result_stall = 1'b0;
  sbrm_pkg::result_t   result;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [ADDR_W-1:0]   paddr        = '0;
  logic [DATA_W-1:0]   pwdata       = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // predictor state: channel energies, frames held, mode
  logic                meter_stereo = 1'b1;
  logic [SUM_W-1:0]    energy_left  = '0;
  logic [SUM_W-1:0]    energy_right = '0;
  logic [CNT_W-1:0]    frames_held  = '0;
  sbrm_pkg::result_t   pending_levels[$];

  // idling knobs, percent of cycles
  int unsigned         send_gap_pct    = 0;
  int unsigned         result_hold_pct = 0;

  int unsigned         level_errors = 0;
  int unsigned         quiet_cycles = 0;

  stereo_block_rms_meter DUT (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_stall  (frame_stall),
    .frame        (frame),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // exact square of a two's complement sample
  function automatic logic [SUM_W-1:0] squared(logic signed [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS-1:0] mag;
    // most negative value maps to 2^(SAMPLE_BITS-1) as unsigned
    mag = s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
    return SUM_W'(mag) * SUM_W'(mag);
  endfunction

  // floor square root, one result bit per trial from the top down
  function automatic logic [ROOT_W-1:0] floor_root(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = ROOT_W; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= x) root = trial;
    end
    return root[ROOT_W-1:0];
  endfunction

  // fold one accepted frame into the energies, queue the levels on a marked frame
  function automatic void accumulate_frame(sbrm_pkg::frame_t f);
    logic [SUM_W-1:0]  sq_l;
    logic [SUM_W-1:0]  sq_r;
    sbrm_pkg::result_t lv;
    // a full block ignores further frames, the mark still closes it
    if (frames_held < MAX_FRAMES) begin
      sq_l = squared(f.sample_left);
      sq_r = meter_stereo ? squared(f.sample_right) : sq_l;
      energy_left  = energy_left + sq_l;
      energy_right = energy_right + sq_r;
      frames_held  = frames_held + 1'b1;
    end
    if (f.last_in_block) begin
      if (frames_held == 0) begin
        lv.rms_left  = '0;
        lv.rms_right = '0;
      end else begin
        lv.rms_left  = floor_root(64'(energy_left) / 64'(frames_held));
        lv.rms_right = floor_root(64'(energy_right) / 64'(frames_held));
      end
      lv.frames_in_block = frames_held;
      pending_levels.push_back(lv);
      energy_left  = '0;
      energy_right = '0;
      frames_held  = '0;
    end
  endfunction

  // mix of full range, extremes, quiet and loud samples
  function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
    case ($urandom_range(5, 0))
      0, 1: return SAMPLE_BITS'($urandom);
      2: begin
        case ($urandom_range(4, 0))
          0: return FULL_NEG;
          1: return FULL_POS;
          2: return SILENCE;
          3: return MINUS_ONE;
          default: return ONE_LSB;
        endcase
      end
      3: return SAMPLE_BITS'(int'($urandom_range(512, 0)) - 256);
      4: return FULL_POS - SAMPLE_BITS'($urandom_range(4000, 0));
      default: return FULL_NEG + SAMPLE_BITS'($urandom_range(4000, 0));
    endcase
  endfunction

  // one frame transfer; valid stays high into the next call unless a gap is rolled
  task automatic send_frame(sbrm_pkg::frame_t f);
    while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct) begin
      frame_valid <= 1'b0;
      @(posedge clk);
    end
    frame_valid <= 1'b1;
    frame       <= f;
    @(posedge clk);
    while (frame_stall) @(posedge clk);
    accumulate_frame(f);
  endtask

  // sender pauses until every queued level has come back
  task automatic hold_until_drained();
    frame_valid <= 1'b0;
    @(posedge clk);
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // drained and past any frame still being squared, safe for a register write
  task automatic wait_quiet();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // setup cycle then access cycle, trailing idle cycle keeps psel edges apart
  task automatic write_reg(logic [ADDR_W-3:0] index, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    // only bit 0 of the mode register exists
    if (index == sbrm_pkg::REG_STEREO_MODE) meter_stereo = value[0];
    @(posedge clk);
  endtask

  task automatic flag_level_error(string what);
    level_errors++;
    if (level_errors <= MISMATCH_SHOWN) $display("level mismatch: %s", what);
  endtask

  // extremes of the samples, full scale and silence, short blocks in stereo
  task automatic test_stereo_extremes();
    send_gap_pct    = 0;
    result_hold_pct = 0;
    // full negative scale gives the largest mean and the largest root
    send_frame(sbrm_pkg::frame_t'{FULL_NEG, FULL_NEG, 1'b1});
    send_frame(sbrm_pkg::frame_t'{SILENCE, SILENCE, 1'b1});
    send_frame(sbrm_pkg::frame_t'{FULL_POS, MINUS_ONE, 1'b0});
    send_frame(sbrm_pkg::frame_t'{FULL_NEG, ONE_LSB, 1'b0});
    send_frame(sbrm_pkg::frame_t'{ONE_LSB, FULL_POS, 1'b1});
    send_frame(sbrm_pkg::frame_t'{MINUS_ONE, SILENCE, 1'b1});
    for (int k = 0; k < 4; k++)
      send_frame(sbrm_pkg::frame_t'{random_sample(), random_sample(), k == 3});
  endtask

  // mono copies left into right; a write past the last register changes nothing
  task automatic test_mono_copy();
    wait_quiet();
    // only bit 0 is kept, so this selects mono
    write_reg(sbrm_pkg::REG_STEREO_MODE, 32'hFFFF_FFFE);
    write_reg(REG_PAST_END, 32'h0000_0001);
    send_frame(sbrm_pkg::frame_t'{FULL_POS, FULL_NEG, 1'b0});
    send_frame(sbrm_pkg::frame_t'{FULL_NEG, SILENCE, 1'b1});
    send_frame(sbrm_pkg::frame_t'{MINUS_ONE, FULL_POS, 1'b1});
    send_frame(sbrm_pkg::frame_t'{SILENCE, FULL_NEG, 1'b1});
    wait_quiet();
    write_reg(sbrm_pkg::REG_STEREO_MODE, 32'h0000_0001);
  endtask

  // fill the block to its limit, then frames past it must be dropped
  task automatic test_full_block();
    send_gap_pct    = 0;
    result_hold_pct = 0;
    for (int k = 0; k < MAX_FRAMES; k++)
      send_frame(sbrm_pkg::frame_t'{FULL_NEG, random_sample(), 1'b0});
    for (int k = 0; k < 3; k++)
      send_frame(sbrm_pkg::frame_t'{random_sample(), random_sample(), 1'b0});
    // marked frame on a full block closes it without entering the sums
    send_frame(sbrm_pkg::frame_t'{random_sample(), random_sample(), 1'b1});
    hold_until_drained();
  endtask

  // random blocks, mostly short, under one idling pattern and one mode
  task automatic test_random_blocks(int frames, int unsigned gap_pct,
                                    int unsigned hold_pct, logic stereo);
    int sent;
    int len;
    wait_quiet();
    write_reg(sbrm_pkg::REG_STEREO_MODE, DATA_W'(stereo));
    send_gap_pct    = gap_pct;
    result_hold_pct = hold_pct;
    sent = 0;
    while (sent < frames) begin
      case ($urandom_range(19, 0))
        0, 1: len = $urandom_range(64, 9);
        default: len = $urandom_range(8, 1);
      endcase
      for (int k = 0; k < len; k++)
        send_frame(sbrm_pkg::frame_t'{random_sample(), random_sample(), k == len - 1});
      sent += len;
      if ($urandom_range(29, 0) == 0) hold_until_drained();
    end
  endtask

  // result side: check the transfer, then roll the stall for the next edge
  always @(posedge clk) begin : check_levels
    sbrm_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_levels.size() == 0) begin
        flag_level_error($sformatf("unexpected transfer rms_left %0d rms_right %0d frames %0d",
                                   result.rms_left, result.rms_right,
                                   result.frames_in_block));
      end else begin
        want = pending_levels.pop_front();
        if (result.rms_left !== want.rms_left)
          flag_level_error($sformatf("rms_left expected %0d got %0d",
                                     want.rms_left, result.rms_left));
        if (result.rms_right !== want.rms_right)
          flag_level_error($sformatf("rms_right expected %0d got %0d",
                                     want.rms_right, result.rms_right));
        if (result.frames_in_block !== want.frames_in_block)
          flag_level_error($sformatf("frames_in_block expected %0d got %0d",
                                     want.frames_in_block, result.frames_in_block));
      end
    end
    result_stall <= (result_hold_pct != 0) && ($urandom_range(99, 0) < result_hold_pct);
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((frame_valid && !frame_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_stereo_extremes();
    test_mono_copy();
    test_full_block();
    // no idling, sender gaps, receiver stalls, then both, alternating the mode
    test_random_blocks(RANDOM_FRAMES / 4, 0, 0, 1'b1);
    test_random_blocks(RANDOM_FRAMES / 4, 77, 0, 1'b0);
    test_random_blocks(RANDOM_FRAMES / 4, 0, 77, 1'b1);
    test_random_blocks(RANDOM_FRAMES - 3 * (RANDOM_FRAMES / 4), 15, 15, 1'b0);
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (level_errors == 0 && pending_levels.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/sbrm_pkg.sv
design/stereo_block_rms_meter.sv
tb/tb_top.sv
